[design/cma3_pkg.sv]
// Package for the three-axis centered moving average core.
// Holds shared widths, the reset half window and depth constants; no dependencies.
`timescale 1ns / 1ps
package cma3_pkg;
  localparam int unsigned MaxHalfDef   = 8;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned HwWidth      = 4;
  localparam logic [HwWidth-1:0] HalfWindowRst = 4'd3;
endpackage

[design/cma3_front.sv]
// Front end: sample window store, stream counters and emit scheduling.
// Depends on cma3_pkg. Issues one emit job at a time to the back end.
`timescale 1ns / 1ps
module cma3_front import cma3_pkg::*; #(
  parameter int unsigned MAX_HALF   = MaxHalfDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  localparam int unsigned Depth = 2 * MAX_HALF + 1,
  localparam int unsigned AW    = $clog2(Depth + 1),
  localparam int unsigned IW    = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [HwWidth-1:0]    half_len_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] in_x_i,
  input  logic [DATA_WIDTH-1:0] in_y_i,
  input  logic [DATA_WIDTH-1:0] in_z_i,
  input  logic                  in_last_i,
  // read port for the back end
  input  logic [IW-1:0]         rd_addr_i,
  output logic [3*DATA_WIDTH-1:0] rd_data_o,
  // job to back end
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output logic [IW-1:0]         job_lo_o,
  output logic [IW-1:0]         job_hi_o,
  output logic                  job_last_o,
  input  logic                  back_idle_i
);
  logic [3*DATA_WIDTH-1:0] win_q [Depth];
  logic [AW-1:0] seen_q, seen_d;
  logic [AW-1:0] pend_q, pend_d;
  logic          flush_q, flush_d;
  logic [AW-1:0] h;
  logic [AW-1:0] h_q, h_d;
  logic [AW-1:0] d, lo, hi, hi_lim;
  logic          accept, emit, busy;

  assign h = (32'(half_len_i) > 32'(MAX_HALF)) ? AW'(MAX_HALF) : AW'(half_len_i);
  // the half length in force is the one seen when the last sample arrived
  assign busy = flush_q || (pend_q > h_q);
  // hold input while jobs remain or the back end is still reading the window
  assign in_stall_o = busy || !back_idle_i;
  assign accept = in_valid_i && !in_stall_o;

  assign d      = pend_q - AW'(1);
  assign lo     = (d > h_q) ? d - h_q : '0;
  assign hi_lim = seen_q - AW'(1);
  always_comb begin
    hi = d + h_q;
    if (hi > hi_lim) hi = hi_lim;
  end
  assign job_valid_o = busy && (pend_q != '0);
  assign job_lo_o    = lo[IW-1:0];
  assign job_hi_o    = hi[IW-1:0];
  assign job_last_o  = flush_q && (pend_q == AW'(1));
  assign emit        = job_valid_o && job_ready_i;

  always_comb begin
    seen_d  = seen_q;
    pend_d  = pend_q;
    flush_d = flush_q;
    h_d     = h_q;
    if (accept) begin
      if (seen_q < AW'(Depth)) seen_d = seen_q + AW'(1);
      if (pend_q < AW'(MAX_HALF + 1)) pend_d = pend_q + AW'(1);
      flush_d = in_last_i;
      h_d     = h;
    end else if (emit) begin
      pend_d = pend_q - AW'(1);
      if (flush_q && pend_q == AW'(1)) begin
        flush_d = 1'b0;
        seen_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      pend_q  <= '0;
      flush_q <= 1'b0;
      h_q     <= '0;
    end else begin
      seen_q  <= seen_d;
      pend_q  <= pend_d;
      flush_q <= flush_d;
      h_q     <= h_d;
    end
  end

  // shift line, newest at index 0
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q[0] <= {in_z_i, in_y_i, in_x_i};
      for (int i = 1; i < Depth; i++) win_q[i] <= win_q[i-1];
    end
  end
  assign rd_data_o = win_q[rd_addr_i];
endmodule

[design/cma3_back.sv]
// Back end: serial window summation and restoring division per axis.
// Depends on cma3_pkg. Reads the front end window one entry per cycle.
`timescale 1ns / 1ps
module cma3_back import cma3_pkg::*; #(
  parameter int unsigned MAX_HALF   = MaxHalfDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  localparam int unsigned Depth = 2 * MAX_HALF + 1,
  localparam int unsigned IW    = $clog2(Depth),
  localparam int unsigned CW    = $clog2(Depth + 1),
  localparam int unsigned SW    = DATA_WIDTH + CW,
  localparam int unsigned BW    = $clog2(SW + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  logic [IW-1:0]           job_lo_i,
  input  logic [IW-1:0]           job_hi_i,
  input  logic                    job_last_i,
  output logic                    idle_o,
  output logic [IW-1:0]           rd_addr_o,
  input  logic [3*DATA_WIDTH-1:0] rd_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DATA_WIDTH-1:0]   avg_x_o,
  output logic [DATA_WIDTH-1:0]   avg_y_o,
  output logic [DATA_WIDTH-1:0]   avg_z_o,
  output logic                    out_last_o
);
  localparam logic [1:0] StIdle = 2'd0, StSum = 2'd1, StDiv = 2'd2, StOut = 2'd3;
  logic [1:0] st_q, st_d;
  logic [IW-1:0] addr_q, hi_q;
  logic [CW-1:0] cnt_q;
  logic          last_q;
  logic [1:0]    ax_q;
  logic [BW-1:0] bit_q;
  logic signed [SW-1:0] sum_q [3];
  logic [SW-1:0] mag_q, rem_q;
  logic          neg_q;
  logic [DATA_WIDTH-1:0] res_q [3];
  logic [SW:0]   trial;
  logic [SW-1:0] rem_sh;
  logic [SW-1:0] quo;

  assign job_ready_o = (st_q == StIdle);
  assign idle_o      = (st_q == StIdle) && !job_valid_i;
  assign rd_addr_o   = addr_q;
  assign out_valid_o = (st_q == StOut);
  assign avg_x_o = res_q[0];
  assign avg_y_o = res_q[1];
  assign avg_z_o = res_q[2];
  assign out_last_o = last_q;

  assign rem_sh = {rem_q[SW-2:0], mag_q[SW-1]};
  assign trial  = {1'b0, rem_sh} - {{(SW+1-CW){1'b0}}, cnt_q};
  assign quo    = {mag_q[SW-2:0], ~trial[SW]};

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (job_valid_i) st_d = StSum;
      StSum:  if (addr_q == hi_q) st_d = StDiv;
      StDiv:  if (bit_q == BW'(0) && ax_q == 2'd2) st_d = StOut;
      StOut:  if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else         st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        addr_q <= job_lo_i;
        hi_q   <= job_hi_i;
        last_q <= job_last_i;
        cnt_q  <= CW'(job_hi_i - job_lo_i) + CW'(1);
        for (int a = 0; a < 3; a++) sum_q[a] <= '0;
      end
      StSum: begin
        // accumulate one stored sample per cycle
        for (int a = 0; a < 3; a++)
          sum_q[a] <= sum_q[a] + SW'($signed(rd_data_i[a*DATA_WIDTH +: DATA_WIDTH]));
        addr_q <= addr_q + IW'(1);
        if (addr_q == hi_q) begin
          ax_q  <= 2'd0;
          bit_q <= BW'(SW);
          neg_q <= 1'b0;
        end
      end
      StDiv: begin
        // load magnitude, then one quotient bit per cycle
        if (bit_q == BW'(SW)) begin
          neg_q <= sum_q[ax_q][SW-1];
          mag_q <= sum_q[ax_q][SW-1] ? SW'(-sum_q[ax_q]) : SW'(sum_q[ax_q]);
          rem_q <= '0;
          bit_q <= bit_q - BW'(1);
        end else begin
          rem_q <= trial[SW] ? rem_sh : trial[SW-1:0];
          mag_q <= quo;
          if (bit_q == BW'(0)) begin
            // last quotient bit lands here; restore the sign
            res_q[ax_q] <= neg_q ? DATA_WIDTH'(-quo) : quo[DATA_WIDTH-1:0];
            ax_q  <= ax_q + 2'd1;
            bit_q <= BW'(SW);
          end else begin
            bit_q <= bit_q - BW'(1);
          end
        end
      end
      default: ;
    endcase
  end
endmodule

[design/centered_moving_average_3axis_core.sv]
// Top level of the three-axis centered moving average core.
// Depends on cma3_pkg, cma3_front and cma3_back.
`timescale 1ns / 1ps
//  channel | handshake            | word
//  in      | in_valid_i/in_stall_o| in_x/y/z, in_last
//  out     | out_valid_o/out_stall_i | avg_x/y/z, out_last
//  cfg     | cfg_valid_i/cfg_ready_o | half window length
// Each output word is built in order: the back end picks up the job, sums the
// samples of its window one by one, divides each axis in turn with the serial
// restoring divider (SW = DATA_WIDTH + 5 at the default depth) and holds the
// result until it is taken. Reset clears counters and sets the half window to 3.
// Input stalls while emit jobs are pending or the back end is busy.
module centered_moving_average_3axis_core import cma3_pkg::*; #(
  parameter int unsigned MAX_HALF   = MaxHalfDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [HwWidth-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] in_x_i,
  input  logic [DATA_WIDTH-1:0] in_y_i,
  input  logic [DATA_WIDTH-1:0] in_z_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] avg_x_o,
  output logic [DATA_WIDTH-1:0] avg_y_o,
  output logic [DATA_WIDTH-1:0] avg_z_o,
  output logic                  out_last_o
);
  localparam int unsigned IW = $clog2(2 * MAX_HALF + 1);
  logic [HwWidth-1:0] half_len_q;
  logic [IW-1:0] rd_addr, job_lo, job_hi;
  logic [3*DATA_WIDTH-1:0] rd_data;
  logic job_valid, job_ready, job_last, back_idle;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) half_len_q <= HalfWindowRst;
    else if (cfg_valid_i) half_len_q <= cfg_data_i;
  end

  cma3_front #(.MAX_HALF(MAX_HALF), .DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni, .half_len_i(half_len_q),
    .in_valid_i, .in_stall_o, .in_x_i, .in_y_i, .in_z_i, .in_last_i,
    .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_lo_o(job_lo), .job_hi_o(job_hi), .job_last_o(job_last),
    .back_idle_i(back_idle)
  );

  cma3_back #(.MAX_HALF(MAX_HALF), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_lo_i(job_lo), .job_hi_i(job_hi), .job_last_i(job_last),
    .idle_o(back_idle), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .out_valid_o, .out_stall_i, .avg_x_o, .avg_y_o, .avg_z_o, .out_last_o
  );
endmodule
